// ----- src/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every edge out of reset
`define ASSERT_ALWAYS(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("assertion failed");

// antecedent implies consequent on the next edge
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- src/tlf_pkg.sv -----
// ---------------------------------------------------------------------------
// tlf_pkg
// types, constants and the arctangent table of the tilt filter
// ---------------------------------------------------------------------------
package tlf_pkg;

    localparam int SAMPLE_BITS         = 16;
    localparam int ANGLE_FRACTION_BITS = 8;
    localparam int CORDIC_STEPS        = 16;
    localparam int STATE_FRAC          = 16;
    localparam int STATE_BITS          = 24;
    localparam int SCALE_SHIFT         = 30 - SAMPLE_BITS;
    localparam int SQ_BITS             = 2 * SAMPLE_BITS;
    localparam int RAD_BITS            = 2 * 30;
    localparam int ROOT_BITS           = 30;
    localparam int SQRT_STEPS          = ROOT_BITS;
    localparam int CORD_BITS           = 36;
    localparam int STEP_BITS           = $clog2(CORDIC_STEPS);
    localparam int OUT_SHIFT           = STATE_FRAC - ANGLE_FRACTION_BITS;
    localparam int OUT_BITS            = 16;

    localparam logic signed [STATE_BITS-1:0] QUARTER_TURN = STATE_BITS'(90 << STATE_FRAC);

    localparam logic [1:0] REG_SMOOTHING = 2'd0;
    localparam logic [1:0] REG_ROTATION  = 2'd1;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [STATE_BITS-1:0]  angle_t;

    typedef struct packed {
        logic busy;
        logic done;
    } ang_stat_t;

    function automatic angle_t atan_deg(input logic [4:0] idx);
        angle_t t;
        unique case (idx)
            5'd0:    t = 24'sd2949120;
            5'd1:    t = 24'sd1740967;
            5'd2:    t = 24'sd919879;
            5'd3:    t = 24'sd466945;
            5'd4:    t = 24'sd234379;
            5'd5:    t = 24'sd117304;
            5'd6:    t = 24'sd58666;
            5'd7:    t = 24'sd29335;
            5'd8:    t = 24'sd14668;
            5'd9:    t = 24'sd7334;
            5'd10:   t = 24'sd3667;
            5'd11:   t = 24'sd1833;
            5'd12:   t = 24'sd917;
            5'd13:   t = 24'sd458;
            5'd14:   t = 24'sd229;
            5'd15:   t = 24'sd115;
            5'd16:   t = 24'sd57;
            5'd17:   t = 24'sd29;
            5'd18:   t = 24'sd14;
            5'd19:   t = 24'sd7;
            5'd20:   t = 24'sd4;
            5'd21:   t = 24'sd2;
            5'd22:   t = 24'sd1;
            default: t = 24'sd0;
        endcase
        return t;
    endfunction

endpackage

// ----- src/tlf_angle_unit.sv -----
// ---------------------------------------------------------------------------
// tlf_angle_unit
// iterative tilt angle: squares, bitwise square root, cordic vectoring
// ---------------------------------------------------------------------------
module tlf_angle_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  tlf_pkg::sample_t   a_in,
    input  tlf_pkg::sample_t   b_in,
    input  tlf_pkg::sample_t   c_in,
    output tlf_pkg::angle_t    angle,
    output tlf_pkg::ang_stat_t stat
);
    import tlf_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_SQB  = 6'b000010,
        ST_SQC  = 6'b000100,
        ST_SQRT = 6'b001000,
        ST_CORD = 6'b010000,
        ST_DONE = 6'b100000
    } ang_state_t;

    ang_state_t                   state_reg, state_next;
    sample_t                      a_reg, b_reg, c_reg;
    logic [SQ_BITS-1:0]           sq_reg, sq_next;
    logic [RAD_BITS-1:0]          nsh_reg, nsh_next;
    logic [SQ_BITS-1:0]           rem_reg, rem_next;
    logic [ROOT_BITS-1:0]         root_reg, root_next;
    logic signed [CORD_BITS-1:0]  x_reg, x_next, y_reg, y_next;
    angle_t                       z_reg, z_next;
    logic [4:0]                   cnt_reg, cnt_next;

    sample_t                      mul_op;
    logic signed [SQ_BITS-1:0]    prod;
    logic [SQ_BITS-1:0]           sq_sum;
    logic [SQ_BITS+1:0]           rem_sh, trial;
    logic                         ge;
    logic signed [CORD_BITS-1:0]  dx, dy;
    angle_t                       t, zc;

    assign mul_op = state_reg == ST_SQB ? b_reg : c_reg;
    assign prod   = mul_op * mul_op;
    assign sq_sum = sq_reg + $unsigned(prod);

    assign rem_sh = {rem_reg, nsh_reg[RAD_BITS-1 -: 2]};
    assign trial  = {2'b00, root_reg, 2'b01};
    assign ge     = rem_sh >= trial;

    assign dx = y_reg >>> cnt_reg[STEP_BITS-1:0];
    assign dy = x_reg >>> cnt_reg[STEP_BITS-1:0];
    assign t  = atan_deg(cnt_reg);

    always_comb begin
        if (z_reg > QUARTER_TURN) begin
            zc = QUARTER_TURN;
        end else if (z_reg < -QUARTER_TURN) begin
            zc = -QUARTER_TURN;
        end else begin
            zc = z_reg;
        end
    end

    assign angle     = -zc;
    assign stat.done = state_reg == ST_DONE;
    assign stat.busy = state_reg != ST_IDLE;

    always_comb begin
        state_next = state_reg;
        sq_next    = sq_reg;
        nsh_next   = nsh_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    state_next = ST_SQB;
                end
            end
            ST_SQB: begin
                sq_next    = $unsigned(prod);
                state_next = ST_SQC;
            end
            ST_SQC: begin
                nsh_next   = {sq_sum, (RAD_BITS-SQ_BITS)'(0)};
                rem_next   = '0;
                root_next  = '0;
                cnt_next   = 5'(SQRT_STEPS - 1);
                state_next = ST_SQRT;
            end
            ST_SQRT: begin
                nsh_next  = nsh_reg << 2;
                rem_next  = ge ? SQ_BITS'(rem_sh - trial) : rem_sh[SQ_BITS-1:0];
                root_next = {root_reg[ROOT_BITS-2:0], ge};
                if (cnt_reg == 5'd0) begin
                    x_next     = CORD_BITS'({1'b0, root_reg[ROOT_BITS-2:0], ge});
                    y_next     = CORD_BITS'(a_reg) <<< SCALE_SHIFT;
                    z_next     = '0;
                    state_next = ST_CORD;
                end else begin
                    cnt_next = cnt_reg - 5'd1;
                end
            end
            ST_CORD: begin
                if (!y_reg[CORD_BITS-1]) begin
                    x_next = x_reg + dx;
                    y_next = y_reg - dy;
                    z_next = z_reg + t;
                end else begin
                    x_next = x_reg - dx;
                    y_next = y_reg + dy;
                    z_next = z_reg - t;
                end
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(CORDIC_STEPS - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && start) begin
            a_reg <= a_in;
            b_reg <= b_in;
            c_reg <= c_in;
        end
        sq_reg   <= sq_next;
        nsh_reg  <= nsh_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
    end

endmodule

// ----- src/tilt_angle_lowpass_filter.sv -----
// ---------------------------------------------------------------------------
// tilt_angle_lowpass_filter
// three-axis tilt angles with exponential low-pass smoothing
// ---------------------------------------------------------------------------
// s_axis beat: one accelerometer sample, x in tdata[15:0], y [31:16], z [47:32]
// m_axis beat: rotation, tilt_x, tilt_y, tilt_z in 16-bit slots of tdata,
//   angles in 1/256 degree; tuser is sample_valid (0 for an all-zero sample,
//   which leaves the filter state alone)
// config: cfg_wr_en with cfg_addr 0 writes the smoothing factor (Q0.16),
//   cfg_addr 1 the rotation source (0 x angle, 1 negated y angle)
// one sample at a time: s_tready is high only while idle
// each axis runs one angle unit pass (squares, square root, cordic vectoring
//   and handoff), then a filter update (multiply, then add into the state)
// an all-zero sample bypasses the angle unit and raises m_tvalid in the
//   cycle after it is accepted
// with m_tready high the filter goes from output back to idle and takes the
//   next sample there
// the result stays on m_tdata until m_tready; no new sample is taken meanwhile
// reset clears the filter state, sets the factor to 3277 and rotation to x
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tilt_angle_lowpass_filter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // accel_x, accel_y, accel_z
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // rotation, tilt_x, tilt_y, tilt_z
    output logic        m_tuser,   // sample_valid
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wr_data
);
    import tlf_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_START = 6'b000010,
        ST_WAIT  = 6'b000100,
        ST_MUL   = 6'b001000,
        ST_ADD   = 6'b010000,
        ST_OUT   = 6'b100000
    } top_state_t;

    top_state_t                state_reg, state_next;
    logic [15:0]               factor_reg;
    logic                      rot_reg;
    sample_t                   ax_reg, ay_reg, az_reg;
    angle_t                    s_reg [3];
    logic [1:0]                axis_reg, axis_next;
    logic                      valid_reg, valid_next;
    logic signed [STATE_BITS:0]     d_reg;
    logic signed [STATE_BITS+17:0]  prod_reg;

    sample_t                   a_sel, b_sel, c_sel, sx, sy, sz;
    angle_t                    angle;
    ang_stat_t                 stat;
    logic                      zero_in;
    logic signed [STATE_BITS+17:0]  rnd;
    logic signed [STATE_BITS:0]     neg_y;

    assign sx = s_tdata[15:0];
    assign sy = s_tdata[31:16];
    assign sz = s_tdata[47:32];
    assign zero_in = sx == '0 && sy == '0 && sz == '0;

    always_comb begin
        unique case (axis_reg)
            2'd0:    begin a_sel = ax_reg; b_sel = ay_reg; c_sel = az_reg; end
            2'd1:    begin a_sel = ay_reg; b_sel = ax_reg; c_sel = az_reg; end
            default: begin a_sel = az_reg; b_sel = ax_reg; c_sel = ay_reg; end
        endcase
    end

    tlf_angle_unit u_angle (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (state_reg == ST_START),
        .a_in    (a_sel),
        .b_in    (b_sel),
        .c_in    (c_sel),
        .angle   (angle),
        .stat    (stat)
    );

    function automatic logic [OUT_BITS-1:0] out_angle(input logic signed [STATE_BITS:0] v);
        logic signed [STATE_BITS+1:0] r;
        r = (STATE_BITS+2)'(v) + (STATE_BITS+2)'(1 << (OUT_SHIFT - 1));
        return OUT_BITS'(r >>> OUT_SHIFT);
    endfunction

    assign neg_y    = -(STATE_BITS+1)'(s_reg[1]);
    assign rnd      = prod_reg + (STATE_BITS+18)'(32768);
    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = state_reg == ST_OUT;
    assign m_tuser  = valid_reg;
    assign m_tdata  = {out_angle((STATE_BITS+1)'(s_reg[2])),
                       out_angle((STATE_BITS+1)'(s_reg[1])),
                       out_angle((STATE_BITS+1)'(s_reg[0])),
                       rot_reg ? out_angle(neg_y) : out_angle((STATE_BITS+1)'(s_reg[0]))};

    always_comb begin
        state_next = state_reg;
        axis_next  = axis_reg;
        valid_next = valid_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    axis_next  = 2'd0;
                    valid_next = !zero_in;
                    state_next = zero_in ? ST_OUT : ST_START;
                end
            end
            ST_START: state_next = ST_WAIT;
            ST_WAIT: begin
                if (stat.done) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:  state_next = ST_ADD;
            ST_ADD: begin
                if (axis_reg == 2'd2) begin
                    state_next = ST_OUT;
                end else begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = ST_START;
                end
            end
            ST_OUT: begin
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            axis_reg   <= '0;
            valid_reg  <= 1'b0;
            factor_reg <= 16'd3277;
            rot_reg    <= 1'b0;
            s_reg[0]   <= '0;
            s_reg[1]   <= '0;
            s_reg[2]   <= '0;
        end else begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
            valid_reg <= valid_next;
            if (cfg_wr_en && cfg_addr == REG_SMOOTHING) begin
                factor_reg <= cfg_wr_data;
            end
            if (cfg_wr_en && cfg_addr == REG_ROTATION) begin
                rot_reg <= cfg_wr_data[0];
            end
            if (state_reg == ST_ADD) begin
                s_reg[axis_reg] <= s_reg[axis_reg] + STATE_BITS'(rnd >>> 16);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_tvalid) begin
            ax_reg <= sx;
            ay_reg <= sy;
            az_reg <= sz;
        end
        if (state_reg == ST_WAIT) begin
            d_reg <= (STATE_BITS+1)'(angle) - (STATE_BITS+1)'(s_reg[axis_reg]);
        end
        if (state_reg == ST_MUL) begin
            prod_reg <= d_reg * $signed({1'b0, factor_reg});
        end
    end

    `ASSERT_ALWAYS(a_one_side, aclk, aresetn, !(s_tready && m_tvalid))
    `ASSERT_ALWAYS(a_axis_range, aclk, aresetn, axis_reg != 2'd3)
    `ASSERT_ALWAYS(a_unit_idle, aclk, aresetn, !(stat.busy && (s_tready || m_tvalid)))
    `ASSERT_NEXT(a_zero_direct, aclk, aresetn, s_tvalid && s_tready && zero_in, m_tvalid && !m_tuser)

endmodule

// ----- sim/tilt_filter_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tilt_filter_checker
// watches the sample and result streams and the register port, predicts the
// smoothed tilt angles for every accepted sample and compares each result
// beat field by field with the oldest prediction
// ---------------------------------------------------------------------------
module tilt_filter_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,
    input  logic        m_tuser,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wr_data,
    output int          mismatches,
    output int          pending
);
    import tlf_pkg::*;

    typedef struct packed {
        logic signed [15:0] rotation;
        logic signed [15:0] tilt_x;
        logic signed [15:0] tilt_y;
        logic signed [15:0] tilt_z;
        logic               sample_valid;
    } tilt_result_t;

    localparam longint ARCTAN_DEG [0:15] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115
    };
    localparam longint RIGHT_ANGLE = 90 * 65536;

    logic [15:0]  weight;
    logic         rot_from_y;
    longint       filt_x, filt_y, filt_z;
    tilt_result_t predicted_q[$];

    function automatic longint unsigned floor_root(input longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // negated arcsine of a over the vector length, 1/65536 degree
    function automatic longint tilt_deg(input longint a, input longint b, input longint c);
        longint xv, yv, ang, dx, dy, bs, cs;
        bs = b * 16384;
        cs = c * 16384;
        xv = longint'(floor_root(longint'(bs * bs) + longint'(cs * cs)));
        yv = a * 16384;
        ang = 0;
        for (int i = 0; i < 16; i++) begin
            dx = yv >>> i;
            dy = xv >>> i;
            if (yv >= 0) begin
                xv += dx; yv -= dy; ang += ARCTAN_DEG[i];
            end else begin
                xv -= dx; yv += dy; ang -= ARCTAN_DEG[i];
            end
        end
        if (ang > RIGHT_ANGLE) ang = RIGHT_ANGLE;
        if (ang < -RIGHT_ANGLE) ang = -RIGHT_ANGLE;
        return -ang;
    endfunction

    function automatic longint lowpass(input longint s, input longint angle, input logic [15:0] k);
        longint d;
        d = angle - s;
        return s + ((d * longint'({1'b0, k}) + 32768) >>> 16);
    endfunction

    function automatic logic [15:0] degrees_out(input longint s);
        longint v;
        v = (s + 128) >>> 8;
        return v[15:0];
    endfunction

    task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t",
                 what, $signed(got), $signed(want), $realtime);
        mismatches++;
    endtask

    assign pending = predicted_q.size();

    always @(posedge aclk) begin
        longint ax, ay, az;
        tilt_result_t r, e;
        if (!aresetn) begin
            weight     <= 16'd3277;
            rot_from_y <= 1'b0;
            filt_x = 0; filt_y = 0; filt_z = 0;
            mismatches = 0;
            predicted_q.delete();
        end else begin
            if (cfg_wr_en) begin
                if (cfg_addr == REG_SMOOTHING) weight <= cfg_wr_data;
                else if (cfg_addr == REG_ROTATION) rot_from_y <= cfg_wr_data[0];
            end
            if (s_tvalid && s_tready) begin
                ax = longint'($signed(s_tdata[15:0]));
                ay = longint'($signed(s_tdata[31:16]));
                az = longint'($signed(s_tdata[47:32]));
                e.sample_valid = (ax != 0) || (ay != 0) || (az != 0);
                if (e.sample_valid) begin
                    filt_x = lowpass(filt_x, tilt_deg(ax, ay, az), weight);
                    filt_y = lowpass(filt_y, tilt_deg(ay, ax, az), weight);
                    filt_z = lowpass(filt_z, tilt_deg(az, ax, ay), weight);
                end
                e.tilt_x   = degrees_out(filt_x);
                e.tilt_y   = degrees_out(filt_y);
                e.tilt_z   = degrees_out(filt_z);
                e.rotation = rot_from_y ? degrees_out(-filt_y) : degrees_out(filt_x);
                predicted_q.push_back(e);
            end
            if (m_tvalid && m_tready) begin
                if (predicted_q.size() == 0) begin
                    $display("mismatch: result beat with nothing expected at %0t", $realtime);
                    mismatches++;
                end else begin
                    e = predicted_q.pop_front();
                    r.rotation     = m_tdata[15:0];
                    r.tilt_x       = m_tdata[31:16];
                    r.tilt_y       = m_tdata[47:32];
                    r.tilt_z       = m_tdata[63:48];
                    r.sample_valid = m_tuser;
                    if (r.rotation !== e.rotation) report("rotation", r.rotation, e.rotation);
                    if (r.tilt_x !== e.tilt_x) report("tilt_x", r.tilt_x, e.tilt_x);
                    if (r.tilt_y !== e.tilt_y) report("tilt_y", r.tilt_y, e.tilt_y);
                    if (r.tilt_z !== e.tilt_z) report("tilt_z", r.tilt_z, e.tilt_z);
                    if (r.sample_valid !== e.sample_valid)
                        report("sample_valid", 16'(r.sample_valid), 16'(e.sample_valid));
                end
            end
        end
    end

endmodule

// ----- sim/tilt_angle_lowpass_filter_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tilt_angle_lowpass_filter_tb
// drives accelerometer samples and register writes into the tilt filter with
// random gaps on both streams; the checker predicts and compares every result
// ---------------------------------------------------------------------------
module tilt_angle_lowpass_filter_tb;
    import tlf_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic        m_tuser;
    logic        cfg_wr_en;
    logic [1:0]  cfg_addr;
    logic [15:0] cfg_wr_data;
    int          mismatches;
    int          pending;
    logic        no_gaps;
    int          samples_sent;
    int          zero_samples;

    tilt_angle_lowpass_filter dut (.*);
    tilt_filter_checker chk (.*);

    always begin
        aclk = 1'b1; #4;
        aclk = 1'b0; #4;
    end

    function automatic int pick_gap();
        return no_gaps ? 0 : $urandom_range(0, 14);
    endfunction

    task automatic send_sample(input logic [15:0] x, input logic [15:0] y, input logic [15:0] z);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {z, y, x};
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        samples_sent++;
        if ({x, y, z} == 48'd0) zero_samples++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        @(posedge aclk);
    endtask

    // vectors with a +-g z axis and x, y within +-g, full random, full-scale x, and rare all-zero
    task automatic random_samples(input int count);
        logic [15:0] x, y, z;
        int g;
        for (int i = 0; i < count; i++) begin
            if (i % 60 == 0) no_gaps = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    g = $urandom_range(1000, 30000);
                    x = 16'($signed($urandom_range(0, 2 * g)) - g);
                    y = 16'($signed($urandom_range(0, 2 * g)) - g);
                    z = 16'(g);
                    if ($urandom_range(0, 1)) z = -z;
                end
                4, 5, 6, 7: begin
                    x = 16'($urandom); y = 16'($urandom); z = 16'($urandom);
                end
                8: begin
                    x = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
                    y = $urandom_range(0, 3) == 0 ? 16'd0 : 16'($urandom);
                    z = $urandom_range(0, 3) == 0 ? 16'd0 : 16'($urandom);
                end
                default: begin
                    x = '0; y = '0; z = '0;
                end
            endcase
            send_sample(x, y, z);
            if (i == count / 2 && count > 100) drain();
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr = '0;
        cfg_wr_data = '0;
        no_gaps = 1'b0;
        samples_sent = 0;
        zero_samples = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset factor and rotation source, then edge cases
        send_sample(16'd0, 16'd0, 16'd0);
        send_sample(16'h7fff, 16'd0, 16'd0);
        send_sample(16'h8000, 16'd0, 16'd0);
        send_sample(16'd0, 16'h7fff, 16'd0);
        send_sample(16'd0, 16'h8000, 16'd0);
        send_sample(16'd0, 16'd0, 16'h7fff);
        send_sample(16'd0, 16'd0, 16'h8000);
        send_sample(16'h8000, 16'h8000, 16'h8000);
        send_sample(16'h7fff, 16'h7fff, 16'h7fff);
        send_sample(16'd1, 16'd0, 16'd0);
        send_sample(16'hffff, 16'd1, 16'hffff);
        send_sample(16'd0, 16'd0, 16'd0);
        drain();

        write_reg(REG_SMOOTHING, 16'hffff);
        write_reg(REG_ROTATION, 16'hffff);
        write_reg(2'd2, 16'd0);
        write_reg(2'd3, 16'd1);
        send_sample(16'h8000, 16'h7fff, 16'd0);
        send_sample(16'd0, 16'd0, 16'd0);
        send_sample(16'h1234, 16'hedcb, 16'h4000);
        random_samples(380);
        drain();

        write_reg(REG_SMOOTHING, 16'd0);
        write_reg(REG_ROTATION, 16'hfffe);
        send_sample(16'h4000, 16'hc000, 16'h2000);
        random_samples(300);
        drain();

        write_reg(REG_SMOOTHING, 16'd1);
        write_reg(REG_ROTATION, 16'd1);
        random_samples(300);
        drain();

        write_reg(REG_SMOOTHING, 16'd6554);
        write_reg(REG_ROTATION, 16'd0);
        random_samples(480);
        drain();

        write_reg(REG_SMOOTHING, 16'h8000);
        write_reg(REG_ROTATION, 16'd1);
        random_samples(470);
        drain();

        $display("covered %0d samples (%0d all-zero) over six register settings",
                 samples_sent, zero_samples);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    always begin
        int gap;
        @(posedge aclk);
        if (aresetn) begin
            gap = pick_gap();
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    initial begin
        #20ms;
        $display("timeout after %0t", $realtime);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
